### rtl/cgbp_pkg.sv
// Package for the conservative grid block pool unit.
// Beat layouts, accumulator entry, sequencer states and fixed constants.
// No dependencies.
package cgbp_pkg;

  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MAX_FACTOR  = 16;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam logic [16:0] QUALITY_ONE = 17'd65536;

  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_AGG_FACTOR  = 2'd2;

  typedef struct packed {
    logic [3:0]         pad;
    logic [15:0]        obs_count;
    logic [31:0]        obstacle_variance;
    logic [31:0]        elevation_variance;
    logic [16:0]        quality;
    logic [23:0]        observation_age;
    logic [15:0]        obstacle_height;
    logic               forbidden;
    logic               obstacle;
    logic               valid_req;
    logic signed [23:0] elevation;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic [11:0]        parent_y;
    logic [9:0]         parent_x;
    logic [15:0]        parent_count;
    logic [31:0]        parent_obstacle_variance;
    logic [31:0]        parent_elevation_variance;
    logic [16:0]        parent_quality;
    logic [23:0]        parent_age;
    logic [15:0]        parent_obstacle_height;
    logic               parent_forbidden;
    logic               parent_obstacle;
    logic               parent_valid;
    logic signed [23:0] parent_elevation;
  } out_beat_t;

  // flags: bit0 obstacle, bit1 forbidden, bit2 all valid
  typedef struct packed {
    logic [2:0]         flags;
    logic [15:0]        max_height;
    logic [23:0]        max_age;
    logic [16:0]        min_quality;
    logic [31:0]        max_elev_var;
    logic [31:0]        max_obst_var;
    logic [15:0]        min_count;
    logic signed [31:0] elev_sum;
    logic [54:0]        elev_sumsq;
  } acc_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_MEAN,
    S_MEAN_WAIT,
    S_SQ,
    S_VAR,
    S_VAR_WAIT,
    S_EMIT
  } state_t;

endpackage

### rtl/cgbp_acc_mem.sv
// Accumulator band memory, one entry per parent column.
// Synchronous write, registered read. Uses cgbp_pkg.
module cgbp_acc_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  cgbp_pkg::acc_t     wdata,
  input  logic [AW-1:0]      raddr,
  output cgbp_pkg::acc_t     rdata
);
  import cgbp_pkg::*;

  acc_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/cgbp_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// 64-bit dividend, 17-bit divisor. Uses cgbp_pkg.
module cgbp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [16:0] rem
);
  import cgbp_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [16:0] d;
  logic [17:0] trial;
  logic        fits;

  assign trial = {rem, quot[63]};
  assign fits  = trial >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      d    <= divisor;
    end else if (busy) begin
      quot <= {quot[62:0], fits};
      rem  <= fits ? 17'(trial - {1'b0, d}) : trial[16:0];
    end
  end

endmodule

### rtl/conservative_grid_block_pool_unit.sv
// Conservative grid block pool unit: top level with raster counters and sequencer.
// Cells merge into their accumulator entry; a full all-valid parent then divides
// for mean and variance before emit. New cells are taken only in the idle state.
// Reset clears positions and output valid, sets default config; accumulator memory is kept.
// Uses cgbp_pkg, cgbp_acc_mem, cgbp_div.
module conservative_grid_block_pool_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // elevation, valid_req, obstacle, forbidden, obstacle_height, observation_age,
  // quality, elevation_variance, obstacle_variance, obs_count, zero pad
  input  logic [167:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // parent_elevation, parent_valid, parent_obstacle, parent_forbidden,
  // parent_obstacle_height, parent_age, parent_quality, parent_elevation_variance,
  // parent_obstacle_variance, parent_count, parent_x, parent_y, zero pad
  output logic [191:0] m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [12:0]  cfg_data
);
  import cgbp_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  state_t state, state_next;

  logic [10:0] grid_width;
  logic [12:0] grid_height;
  logic [4:0]  aggregation_factor;
  logic [12:0] w;
  logic [12:0] h;
  logic [4:0]  f;

  logic [9:0]  cx, px;
  logic [11:0] ry, py;
  logic [3:0]  sx, sy;
  logic        x_end, y_end, sx_end, sy_end;

  in_beat_t    in_beat, in_r;
  logic signed [47:0] sq;
  logic [54:0] sq_r;
  logic        first_r, last_r, complete_r;
  logic [9:0]  px_r;
  logic [11:0] py_r;

  acc_t        rd, merged, acc_r;
  logic        valid_r;
  logic [8:0]  n_r;
  logic [16:0] nn_r;
  logic [31:0] abs_s;
  logic [63:0] ssq_r, nsq_r;
  logic signed [23:0] mean_r;
  logic [63:0] var_r;
  logic [32:0] evar_sum;
  logic [31:0] evar;

  logic        accept, mem_we, div_start, div_done, emit_go;
  logic [AW+9:0] raddr_ext, waddr_ext;
  logic [63:0] div_dividend;
  logic [16:0] div_divisor;
  logic [63:0] div_quot;
  logic [16:0] div_rem;
  out_beat_t   out_beat;

  assign in_beat = in_beat_t'(s_tdata);

  always_comb begin
    if (grid_width == 11'd0) begin
      w = 13'd1;
    end else if (13'(grid_width) > 13'(MAX_WIDTH)) begin
      w = 13'(MAX_WIDTH);
    end else begin
      w = 13'(grid_width);
    end
    if (grid_height == 13'd0) begin
      h = 13'd1;
    end else if (grid_height > 13'(MAX_HEIGHT)) begin
      h = 13'(MAX_HEIGHT);
    end else begin
      h = grid_height;
    end
    if (aggregation_factor == 5'd0) begin
      f = 5'd1;
    end else if (aggregation_factor > 5'(MAX_FACTOR)) begin
      f = 5'(MAX_FACTOR);
    end else begin
      f = aggregation_factor;
    end
  end

  assign x_end  = 13'(cx) == w - 13'd1;
  assign y_end  = 13'(ry) == h - 13'd1;
  assign sx_end = 5'(sx) == f - 5'd1;
  assign sy_end = 5'(sy) == f - 5'd1;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (accept) state_next = S_UPD;
      S_UPD:       state_next = !last_r ? S_IDLE : (complete_r && merged.flags[2]) ? S_MEAN
                                                                                  : S_EMIT;
      S_MEAN:      state_next = S_MEAN_WAIT;
      S_MEAN_WAIT: if (div_done) state_next = S_SQ;
      S_SQ:        state_next = S_VAR;
      S_VAR:       state_next = S_VAR_WAIT;
      S_VAR_WAIT:  if (div_done) state_next = S_EMIT;
      S_EMIT:      if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == S_IDLE);
    mem_we    = (state == S_UPD);
    div_start = (state == S_MEAN) || (state == S_VAR);
    emit_go   = (state == S_EMIT) && (!m_tvalid || m_tready);
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      grid_width         <= 11'd1024;
      grid_height        <= 13'd1024;
      aggregation_factor <= 5'd2;
      cx <= '0; sx <= '0; px <= '0;
      ry <= '0; sy <= '0; py <= '0;
      m_tvalid           <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  grid_width <= cfg_data[10:0];
          CFG_GRID_HEIGHT: grid_height <= cfg_data;
          CFG_AGG_FACTOR:  aggregation_factor <= cfg_data[4:0];
          default: ;
        endcase
        if (cfg_index inside {CFG_GRID_WIDTH, CFG_GRID_HEIGHT, CFG_AGG_FACTOR}) begin
          cx <= '0; sx <= '0; px <= '0;
          ry <= '0; sy <= '0; py <= '0;
        end
      end else if (accept) begin
        if (x_end) begin
          cx <= '0; sx <= '0; px <= '0;
          if (y_end) begin
            ry <= '0; sy <= '0; py <= '0;
          end else begin
            ry <= ry + 12'd1;
            if (sy_end) begin
              sy <= '0;
              py <= py + 12'd1;
            end else begin
              sy <= sy + 4'd1;
            end
          end
        end else begin
          cx <= cx + 10'd1;
          if (sx_end) begin
            sx <= '0;
            px <= px + 10'd1;
          end else begin
            sx <= sx + 4'd1;
          end
        end
      end
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign sq = in_beat.elevation * in_beat.elevation;

  always_comb begin
    if (first_r) begin
      merged.flags        = {in_r.valid_req, in_r.forbidden, in_r.obstacle};
      merged.max_height   = in_r.obstacle_height;
      merged.max_age      = in_r.observation_age;
      merged.min_quality  = (in_r.quality > QUALITY_ONE) ? QUALITY_ONE : in_r.quality;
      merged.max_elev_var = in_r.elevation_variance;
      merged.max_obst_var = in_r.obstacle_variance;
      merged.min_count    = in_r.obs_count;
      merged.elev_sum     = 32'(in_r.elevation);
      merged.elev_sumsq   = sq_r;
    end else begin
      merged.flags = {rd.flags[2] & in_r.valid_req, rd.flags[1] | in_r.forbidden,
                      rd.flags[0] | in_r.obstacle};
      merged.max_height   = (in_r.obstacle_height > rd.max_height) ? in_r.obstacle_height
                                                                   : rd.max_height;
      merged.max_age      = (in_r.observation_age > rd.max_age) ? in_r.observation_age
                                                                : rd.max_age;
      merged.min_quality  = (in_r.quality < rd.min_quality) ? in_r.quality : rd.min_quality;
      merged.max_elev_var = (in_r.elevation_variance > rd.max_elev_var)
                            ? in_r.elevation_variance : rd.max_elev_var;
      merged.max_obst_var = (in_r.obstacle_variance > rd.max_obst_var)
                            ? in_r.obstacle_variance : rd.max_obst_var;
      merged.min_count    = (in_r.obs_count < rd.min_count) ? in_r.obs_count
                                                            : rd.min_count;
      merged.elev_sum     = rd.elev_sum + 32'(in_r.elevation);
      merged.elev_sumsq   = rd.elev_sumsq + sq_r;
    end
  end

  assign abs_s = acc_r.elev_sum[31] ? 32'(-acc_r.elev_sum) : acc_r.elev_sum;

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r       <= in_beat;
      sq_r       <= 55'(sq[46:0]);
      first_r    <= (sx == 4'd0) && (sy == 4'd0);
      last_r     <= (sx_end || x_end) && (sy_end || y_end);
      complete_r <= sx_end && sy_end;
      px_r       <= px;
      py_r       <= py;
    end
    case (state)
      S_UPD: begin
        acc_r   <= merged;
        valid_r <= complete_r && merged.flags[2];
        n_r     <= 9'(f * f);
        mean_r  <= '0;
        var_r   <= '0;
      end
      S_MEAN_WAIT: begin
        nn_r <= 17'(n_r * n_r);
        if (div_done) begin
          mean_r <= acc_r.elev_sum[31] ? -24'(div_quot + 64'(div_rem != 17'd0))
                                       : 24'(div_quot);
        end
      end
      S_SQ: begin
        ssq_r <= {32'd0, abs_s} * {32'd0, abs_s};
        nsq_r <= {55'd0, n_r} * {9'd0, acc_r.elev_sumsq};
      end
      S_VAR_WAIT: begin
        if (div_done) begin
          var_r <= div_quot;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (state == S_MEAN) begin
      div_dividend = {32'd0, abs_s};
      div_divisor  = {8'd0, n_r};
    end else begin
      div_dividend = (nsq_r >= ssq_r) ? nsq_r - ssq_r : 64'd0;
      div_divisor  = nn_r;
    end
  end

  assign raddr_ext = {{AW{1'b0}}, px};
  assign waddr_ext = {{AW{1'b0}}, px_r};

  cgbp_acc_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr_ext[AW-1:0]),
    .wdata (merged),
    .raddr (raddr_ext[AW-1:0]),
    .rdata (rd)
  );

  cgbp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign evar_sum = {1'b0, acc_r.max_elev_var} + {1'b0, var_r[31:0]};
  assign evar = (var_r[63:32] != 32'd0 || evar_sum[32]) ? 32'hFFFF_FFFF : evar_sum[31:0];

  always_comb begin
    out_beat.pad                       = '0;
    out_beat.parent_y                  = py_r;
    out_beat.parent_x                  = px_r;
    out_beat.parent_count              = acc_r.min_count;
    out_beat.parent_obstacle_variance  = acc_r.max_obst_var;
    out_beat.parent_elevation_variance = evar;
    out_beat.parent_quality            = acc_r.min_quality;
    out_beat.parent_age                = acc_r.max_age;
    out_beat.parent_obstacle_height    = acc_r.max_height;
    out_beat.parent_forbidden          = acc_r.flags[1] || !valid_r;
    out_beat.parent_obstacle           = acc_r.flags[0];
    out_beat.parent_valid              = valid_r;
    out_beat.parent_elevation          = mean_r;
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_tdata <= out_beat;
    end
  end

endmodule

### tb/sv/tb.sv
// Self-checking testbench for conservative_grid_block_pool_unit.
// Streams raster map cells under random gaps and stalls and checks each pooled parent
// against its directed or predicted value. Depends on cgbp_pkg and the RTL under rtl/.
module tb;
  import cgbp_pkg::*;

  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int         HOLD_CYCLES = 400;
  localparam int         DRAIN_WAIT  = 150;
  localparam longint     CYCLE_LIMIT = 1000000;

  typedef enum logic { ROW_CFG, ROW_CELL } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  index;
    logic [12:0] value;
    in_beat_t    beat;
    bit          has_exp;
    out_beat_t   exp;
  } stim_row_t;

  typedef struct {
    logic [2:0]  flags;
    logic [15:0] max_height;
    logic [23:0] max_age;
    logic [16:0] min_quality;
    logic [31:0] max_elev_var;
    logic [31:0] max_obst_var;
    logic [15:0] min_count;
    longint      elev_sum;
    logic [63:0] elev_sumsq;
  } parent_acc_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  in_beat_t     s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  out_beat_t    m_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [12:0]  cfg_data = '0;

  parent_acc_t  band_acc [1024];
  int unsigned  grid_w = 1024, grid_h = 1024, factor = 2;
  int unsigned  col_pos = 0, row_pos = 0;
  out_beat_t    parent_q [$];
  stim_row_t    directed [$];

  int unsigned  cells_sent = 0, parents_seen = 0, mismatches = 0, settings_run = 0;
  int unsigned  burst_left = 0;
  longint       cycles = 0;
  int           elev_base = 0;
  bit           hold_go = 1'b0, hold_done = 1'b0;
  int unsigned  hold_left = 0, stall_phase = 0;
  int unsigned  stall_mode = 0;

  conservative_grid_block_pool_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic in_beat_t mk_in(int e, bit v, bit o, bit fb, int unsigned h,
                                     int unsigned age, int unsigned q, logic [31:0] ev,
                                     logic [31:0] ov, int unsigned cnt);
    in_beat_t c;
    c = '0;
    c.elevation = e[23:0];
    c.valid_req = v;
    c.obstacle = o;
    c.forbidden = fb;
    c.obstacle_height = h[15:0];
    c.observation_age = age[23:0];
    c.quality = q[16:0];
    c.elevation_variance = ev;
    c.obstacle_variance = ov;
    c.obs_count = cnt[15:0];
    return c;
  endfunction

  function automatic out_beat_t mk_out(int e, bit v, bit o, bit fb, int unsigned h,
                                       int unsigned age, int unsigned q, logic [31:0] ev,
                                       logic [31:0] ov, int unsigned cnt, int unsigned x,
                                       int unsigned y);
    out_beat_t r;
    r = '0;
    r.parent_elevation = e[23:0];
    r.parent_valid = v;
    r.parent_obstacle = o;
    r.parent_forbidden = fb;
    r.parent_obstacle_height = h[15:0];
    r.parent_age = age[23:0];
    r.parent_quality = q[16:0];
    r.parent_elevation_variance = ev;
    r.parent_obstacle_variance = ov;
    r.parent_count = cnt[15:0];
    r.parent_x = x[9:0];
    r.parent_y = y[11:0];
    return r;
  endfunction

  // Fold one cell into its parent entry; return 1 with the parent when it closes.
  function automatic bit pool_cell(input in_beat_t c, output out_beat_t r);
    int unsigned w, h, f, cx, ry, px, py, a, endx, endy;
    longint      e, s, n, mean;
    logic [63:0] num, s2, pvar, evar;
    logic [2:0]  fl;
    bit          valid, closes;
    w = clamp_dim(grid_w, 1024);
    h = clamp_dim(grid_h, MAX_HEIGHT);
    f = clamp_dim(factor, MAX_FACTOR);
    cx = col_pos;
    ry = row_pos;
    r = '0;
    if (cx >= w || ry >= h) begin
      cx = 0;
      ry = 0;
    end
    px = cx / f;
    py = ry / f;
    a = px % 1024;
    e = {{40{c.elevation[23]}}, c.elevation};
    fl = {c.valid_req, c.forbidden, c.obstacle};
    if (cx % f == 0 && ry % f == 0) begin
      band_acc[a].flags = fl;
      band_acc[a].max_height = c.obstacle_height;
      band_acc[a].max_age = c.observation_age;
      band_acc[a].min_quality = (c.quality > QUALITY_ONE) ? QUALITY_ONE : c.quality;
      band_acc[a].max_elev_var = c.elevation_variance;
      band_acc[a].max_obst_var = c.obstacle_variance;
      band_acc[a].min_count = c.obs_count;
      band_acc[a].elev_sum = e;
      band_acc[a].elev_sumsq = e * e;
    end else begin
      band_acc[a].flags = {band_acc[a].flags[2] & fl[2], band_acc[a].flags[1:0] | fl[1:0]};
      if (c.obstacle_height > band_acc[a].max_height)
        band_acc[a].max_height = c.obstacle_height;
      if (c.observation_age > band_acc[a].max_age) band_acc[a].max_age = c.observation_age;
      if (c.quality < band_acc[a].min_quality) band_acc[a].min_quality = c.quality;
      if (c.elevation_variance > band_acc[a].max_elev_var)
        band_acc[a].max_elev_var = c.elevation_variance;
      if (c.obstacle_variance > band_acc[a].max_obst_var)
        band_acc[a].max_obst_var = c.obstacle_variance;
      if (c.obs_count < band_acc[a].min_count)
        band_acc[a].min_count = c.obs_count;
      band_acc[a].elev_sum += e;
      band_acc[a].elev_sumsq += e * e;
    end
    endx = px * f + f;
    endy = py * f + f;
    closes = (cx == ((endx < w) ? endx : w) - 1) && (ry == ((endy < h) ? endy : h) - 1);
    if (closes) begin
      valid = (endx <= w) && (endy <= h) && band_acc[a].flags[2];
      mean = 0;
      pvar = '0;
      if (valid) begin
        n = f * f;
        s = band_acc[a].elev_sum;
        mean = s / n;
        if (s % n != 0 && s < 0) mean -= 1;
        s2 = (s < 0) ? -s : s;
        s2 = s2 * s2;
        num = n * band_acc[a].elev_sumsq;
        pvar = (num >= s2) ? (num - s2) / (n * n) : 64'd0;
      end
      evar = band_acc[a].max_elev_var + pvar;
      if (evar > 64'hFFFF_FFFF) evar = 64'hFFFF_FFFF;
      r.parent_elevation = mean[23:0];
      r.parent_valid = valid;
      r.parent_obstacle = band_acc[a].flags[0];
      r.parent_forbidden = band_acc[a].flags[1] | ~valid;
      r.parent_obstacle_height = band_acc[a].max_height;
      r.parent_age = band_acc[a].max_age;
      r.parent_quality = band_acc[a].min_quality;
      r.parent_elevation_variance = evar[31:0];
      r.parent_obstacle_variance = band_acc[a].max_obst_var;
      r.parent_count = band_acc[a].min_count;
      r.parent_x = px[9:0];
      r.parent_y = py[11:0];
    end
    cx++;
    if (cx >= w) begin
      cx = 0;
      ry++;
      if (ry >= h) ry = 0;
    end
    col_pos = cx;
    row_pos = ry;
    return closes;
  endfunction

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (parent_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRID_WIDTH:  grid_w = val & 13'h7FF;
      CFG_GRID_HEIGHT: grid_h = val;
      CFG_AGG_FACTOR:  factor = val & 13'h1F;
      default:         return;
    endcase
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic apply_grid(int unsigned w, int unsigned h, int unsigned f);
    wait_drained();
    write_reg(CFG_GRID_WIDTH, w[12:0]);
    write_reg(CFG_GRID_HEIGHT, h[12:0]);
    write_reg(CFG_AGG_FACTOR, f[12:0]);
    settings_run++;
  endtask

  // Offer one cell in bursts; predict on the accepting edge.
  task automatic send_cell(in_beat_t c, bit has_exp, out_beat_t exp);
    int unsigned gap;
    out_beat_t   pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= c;
    do @(posedge clk); while (!s_tready);
    cells_sent++;
    if (pool_cell(c, pred)) parent_q.insert(parent_q.size(), has_exp ? exp : pred);
  endtask

  function automatic in_beat_t rand_cell();
    in_beat_t c;
    c = '0;
    case ($urandom_range(0, 5))
      0:       c.elevation = $urandom;
      1:       c.elevation = ($urandom_range(0, 1) == 1) ? 24'h800000 : 24'h7FFFFF;
      default: c.elevation = elev_base + int'($urandom_range(0, 400)) - 200;
    endcase
    c.valid_req = ($urandom_range(0, 15) != 0);
    c.obstacle = ($urandom_range(0, 7) == 0);
    c.forbidden = ($urandom_range(0, 7) == 0);
    c.obstacle_height = $urandom;
    c.observation_age = $urandom;
    c.quality = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    c.elevation_variance = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5000);
    c.obstacle_variance = $urandom;
    c.obs_count = $urandom;
    return c;
  endfunction

  task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0s: expected %0h, got %0h (parent %0d)", name, exp, act,
                 parents_seen);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= $urandom_range(0, 1);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (parent_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected parent beat %0h", m_tdata);
      end else begin
        out_beat_t e;
        e = parent_q.pop_front();
        check_field("parent_elevation", e.parent_elevation, m_tdata.parent_elevation);
        check_field("parent_valid", e.parent_valid, m_tdata.parent_valid);
        check_field("parent_obstacle", e.parent_obstacle, m_tdata.parent_obstacle);
        check_field("parent_forbidden", e.parent_forbidden, m_tdata.parent_forbidden);
        check_field("parent_obstacle_height", e.parent_obstacle_height,
                    m_tdata.parent_obstacle_height);
        check_field("parent_age", e.parent_age, m_tdata.parent_age);
        check_field("parent_quality", e.parent_quality, m_tdata.parent_quality);
        check_field("parent_elevation_variance", e.parent_elevation_variance,
                    m_tdata.parent_elevation_variance);
        check_field("parent_obstacle_variance", e.parent_obstacle_variance,
                    m_tdata.parent_obstacle_variance);
        check_field("parent_count", e.parent_count, m_tdata.parent_count);
        check_field("parent_x", e.parent_x, m_tdata.parent_x);
        check_field("parent_y", e.parent_y, m_tdata.parent_y);
      end
      parents_seen++;
    end
  end

  task automatic add_cfg(logic [1:0] idx, int unsigned val);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.index = idx;
    row.value = val[12:0];
    row.beat = '0;
    row.has_exp = 1'b0;
    row.exp = '0;
    directed.insert(directed.size(), row);
  endtask

  task automatic add_cell(in_beat_t c, bit has_exp, out_beat_t exp);
    stim_row_t row;
    row.kind = ROW_CELL;
    row.index = '0;
    row.value = '0;
    row.beat = c;
    row.has_exp = has_exp;
    row.exp = exp;
    directed.insert(directed.size(), row);
  endtask

  initial begin
    int unsigned phase_w [10] = '{80, 2047, 7, 16, 1024, 0, 3, 1, 6, 12};
    int unsigned phase_h [10] = '{4, 1, 7, 4096, 4, 0, 8191, 8, 5, 8};
    int unsigned phase_f [10] = '{2, 1, 3, 16, 1, 0, 31, 1, 4, 4};
    int unsigned phase_n [10] = '{80, 30, 98, 256, 60, 20, 40, 30, 60, 340};
    out_beat_t   none;
    none = '0;

    // Factor zero acts as one: every cell is its own parent.
    add_cfg(CFG_GRID_WIDTH, 3);
    add_cfg(CFG_GRID_HEIGHT, 1);
    add_cfg(CFG_AGG_FACTOR, 0);
    add_cell(mk_in(-8388608, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1,
             mk_out(-8388608, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cell(mk_in(8388607, 1, 1, 1, 65535, 16777215, 131071, 32'hFFFFFFFF, 32'hFFFFFFFF,
                   65535), 1,
             mk_out(8388607, 1, 1, 1, 65535, 16777215, 65536, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    65535, 1, 0));
    add_cell(mk_in(1234, 0, 0, 0, 7, 8, 65536, 5, 6, 9), 1,
             mk_out(0, 0, 0, 1, 7, 8, 65536, 5, 6, 9, 2, 0));
    add_cell(mk_in(-1, 1, 0, 0, 1, 2, 3, 4, 5, 6), 1,
             mk_out(-1, 1, 0, 0, 1, 2, 3, 4, 5, 6, 0, 0));
    // 3x3 grid, factor 2: a full parent that saturates variance; the rest are edge parents.
    add_cfg(CFG_GRID_HEIGHT, 3);
    add_cfg(CFG_AGG_FACTOR, 2);
    add_cell(mk_in(-8388608, 1, 0, 0, 10, 100, 60000, 32'hFFFFFFF0, 1, 500), 0, none);
    add_cell(mk_in(8388607, 1, 0, 0, 20, 50, 70000, 3, 2, 400), 0, none);
    add_cell(mk_in(42, 1, 1, 0, 5, 5, 5, 5, 5, 5), 0, none);
    add_cell(mk_in(-8388608, 1, 0, 0, 30, 70, 65536, 7, 9, 300), 0, none);
    add_cfg(CFG_UNUSED, 5);
    add_cell(mk_in(8388607, 1, 0, 0, 1, 1, 1, 1, 1, 1), 0, none);
    add_cell(mk_in(-7, 1, 0, 1, 2, 3, 4, 5, 6, 7), 0, none);
    add_cell(mk_in(-3, 1, 0, 0, 9, 9, 9, 9, 9, 9), 0, none);
    add_cell(mk_in(100, 0, 0, 0, 8, 8, 8, 8, 8, 8), 0, none);
    add_cell(mk_in(-100, 1, 1, 1, 65535, 0, 0, 0, 0, 0), 0, none);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(directed[i].index, directed[i].value);
      end else begin
        send_cell(directed[i].beat, directed[i].has_exp, directed[i].exp);
      end
    end

    for (int p = 0; p < 10; p++) begin
      apply_grid(phase_w[p], phase_h[p], phase_f[p]);
      elev_base = int'($urandom_range(0, 16000000)) - 8000000;
      if (phase_w[p] == 1024) hold_go <= 1'b1;
      for (int k = 0; k < phase_n[p]; k++) send_cell(rand_cell(), 0, none);
    end

    wait_drained();
    $display("%0d cells sent over %0d grid settings, %0d parents checked, %0d mismatches",
             cells_sent, settings_run, parents_seen, mismatches);
    if (mismatches == 0 && parent_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
